// ===== rtl/rac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rac_pkg;

    localparam int          CACHE_ENTRIES_DEF = 1024;
    localparam int          ADDR_W            = 24;
    localparam int          TIME_W            = 32;
    localparam int          TTL_W             = 16;
    localparam int          SLOT_W            = 10;
    localparam int          HASH_SHIFT        = 16;
    localparam logic [31:0] HASH_MULT         = 32'h045d_9f3b;
    localparam logic [TTL_W-1:0] TTL_RESET    = 16'd60;
    localparam int          QUEUE_DEPTH       = 4;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } t_back_state;

    // Status that the back end reports to the rest of the block.
    typedef struct packed {
        logic pop;
        logic ready;
    } t_back_stat;

    // One mixing round; the product keeps its low 32 bits.
    function automatic logic [31:0] hash_round(input logic [31:0] x);
        logic [31:0] m;
        m = x ^ (x >> HASH_SHIFT);
        return m * HASH_MULT;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/recent_address_cache_ttl_top.sv =====
// A query passes the front's 3 hash stages, a 4-entry queue that decouples the
// two ends, and the back end's IDLE, EVAL and DONE states before its result is
// registered; a record skips EVAL. The back end pops no new item until back in
// IDLE and waits in DONE while the output stalls. Configuration writes are taken
// at any time. Reset: synchronous, active low; the TTL returns to 60 and a clearing
// pass zeroes every table entry, one per cycle, holding s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module recent_address_cache_ttl_top
    import rac_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [55:0]      s_axis_tdata,  // address[23:0], now_seconds[55:24]
    input  wire logic [0:0]       s_axis_tuser,  // func[0]
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // hit[0], slot[10:1], zero[15:11]
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [TTL_W-1:0] i_cfg_data     // ttl_seconds
);

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int ITEM_W = 1 + ADDR_W + TIME_W + IDX_W;

    logic [TTL_W-1:0]  r_ttl;
    logic              w_push, w_q_full, w_q_valid;
    logic [ITEM_W-1:0] w_push_item, w_head_item;
    t_back_stat        w_bstat;
    logic              w_hit;
    logic [SLOT_W-1:0] w_slot;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {5'b0, w_slot, w_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ttl <= i_cfg_data;
        end
    end

    rac_front #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_bstat.ready),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_func  (s_axis_tuser[0]),
        .i_addr  (s_axis_tdata[ADDR_W-1:0]),
        .i_now   (s_axis_tdata[ADDR_W +: TIME_W]),
        .o_push  (w_push),
        .i_full  (w_q_full),
        .o_item  (w_push_item)
    );

    rac_queue #(
        .DATA_W(ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_bstat.pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_item)
    );

    rac_back #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_head_item),
        .i_ttl     (r_ttl),
        .o_stat    (w_bstat),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_hit     (w_hit),
        .o_slot    (w_slot)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready && !w_bstat.ready))
        else $error("input transfer accepted during the table clearing pass");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("front end pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_bstat.pop && !w_q_valid))
        else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/rac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rac_front
    import rac_pkg::*;
#(
    parameter  int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W         = $clog2(CACHE_ENTRIES),
    localparam int ITEM_W        = 1 + ADDR_W + TIME_W + IDX_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_func,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [TIME_W-1:0] i_now,
    output logic                   o_push,
    input  wire logic              i_full,
    output logic [ITEM_W-1:0]      o_item
);

    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(CACHE_ENTRIES - 1);

    logic              r_v1, r_v2, r_v3;
    logic              r_f1, r_f2, r_f3;
    logic [ADDR_W-1:0] r_a1, r_a2, r_a3;
    logic [TIME_W-1:0] r_t1, r_t2, r_t3;
    logic [31:0]       r_h1, r_h2;
    logic [IDX_W-1:0]  r_idx3;
    logic [31:0]       w_mix;
    logic              w_adv;

    // The whole hash pipeline moves together; it halts only when its last
    // stage holds an item that the queue cannot take.
    assign w_adv   = !r_v3 || !i_full;
    assign o_ready = w_adv && i_en;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = {r_f3, r_a3, r_t3, r_idx3};
    assign w_mix   = r_h2 ^ (r_h2 >> HASH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid && o_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1   <= i_func;
            r_a1   <= i_addr;
            r_t1   <= i_now;
            r_h1   <= hash_round(32'(i_addr));
            r_f2   <= r_f1;
            r_a2   <= r_a1;
            r_t2   <= r_t1;
            r_h2   <= hash_round(r_h1);
            r_f3   <= r_f2;
            r_a3   <= r_a2;
            r_t3   <= r_t2;
            r_idx3 <= w_mix[IDX_W-1:0] & IDX_MASK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rac_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rac_queue
    import rac_pkg::*;
#(
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rac_back
    import rac_pkg::*;
#(
    parameter  int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W         = $clog2(CACHE_ENTRIES),
    localparam int ITEM_W        = 1 + ADDR_W + TIME_W + IDX_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire logic [ITEM_W-1:0] i_item,
    input  wire logic [TTL_W-1:0]  i_ttl,
    output t_back_stat             o_stat,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_hit,
    output logic [SLOT_W-1:0]      o_slot
);

    localparam int ENT_W = ADDR_W + TIME_W;

    t_back_state       r_state, n_state;
    logic [IDX_W-1:0]  r_clr;
    logic [ITEM_W-1:0] r_item;
    logic [ENT_W-1:0]  r_rd;
    logic              r_res_hit;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;

    logic [ENT_W-1:0]  r_mem [CACHE_ENTRIES];

    logic              w_we, w_re, w_pop, w_load;
    logic [IDX_W-1:0]  w_wa, w_ra;
    logic [ENT_W-1:0]  w_wd;

    logic              w_in_func;
    logic [ADDR_W-1:0] w_in_addr;
    logic [TIME_W-1:0] w_in_now;
    logic [IDX_W-1:0]  w_in_idx;

    logic [ADDR_W-1:0] w_addr;
    logic [TIME_W-1:0] w_now;
    logic [IDX_W-1:0]  w_idx;
    logic [31:0]       w_idx_ext;
    logic [TIME_W-1:0] w_age;
    logic              w_fresh, w_hit;

    assign w_in_func = i_item[ITEM_W-1];
    assign w_in_addr = i_item[ITEM_W-2 -: ADDR_W];
    assign w_in_now  = i_item[IDX_W +: TIME_W];
    assign w_in_idx  = i_item[IDX_W-1:0];

    assign w_addr    = r_item[ITEM_W-2 -: ADDR_W];
    assign w_now     = r_item[IDX_W +: TIME_W];
    assign w_idx     = r_item[IDX_W-1:0];
    assign w_idx_ext = 32'(w_idx);

    // A stored time ahead of now gives a negative age, which counts as fresh.
    assign w_age   = w_now - r_rd[TIME_W-1:0];
    assign w_fresh = w_age[TIME_W-1] || (w_age <= TIME_W'(i_ttl));
    assign w_hit   = (w_addr != '0) && (r_rd[ENT_W-1 -: ADDR_W] == w_addr) && w_fresh;

    assign o_stat.pop   = w_pop;
    assign o_stat.ready = (r_state != ST_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_slot       = r_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_pop   = 1'b0;
        w_load  = 1'b0;
        w_wa    = w_in_idx;
        w_ra    = w_in_idx;
        w_wd    = {w_in_addr, w_in_now};
        unique case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = '0;
                if (r_clr == IDX_W'(CACHE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    w_pop = 1'b1;
                    if (w_in_func == FUNC_RECORD) begin
                        w_we    = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        w_re    = 1'b1;
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_item <= i_item;
        end
        if (w_pop) begin
            r_res_hit <= 1'b0;
        end else if (r_state == ST_EVAL) begin
            r_res_hit <= w_hit;
        end
        if (w_load) begin
            r_out_hit  <= r_res_hit;
            r_out_slot <= w_idx_ext[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
